FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the table parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define XSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define XSP_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/xsp_pkg.sv
// ----------------------------------------------------------------------------
// xsp_pkg
// Types and constants shared by the table stream parser modules.
// ----------------------------------------------------------------------------
package xsp_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned OUT_DATA_W     = 80;

  localparam logic [15:0] KIND_TABLE  = 16'd16;
  localparam logic [15:0] KIND_FLOAT  = 16'd1;
  localparam logic [15:0] KIND_STRING = 16'd2;
  localparam logic [15:0] KIND_BLANK  = 16'd5;
  localparam logic [15:0] HDR_SIZE    = 16'd4;
  localparam logic [7:0]  FLT_LAST    = 8'd7;

  typedef enum logic [2:0] {
    EV_DIMS      = 3'd0,
    EV_STR_BYTE  = 3'd1,
    EV_STR_EMPTY = 3'd2,
    EV_FLT_BYTE  = 3'd3,
    EV_UNKNOWN   = 3'd4,
    EV_NOT_TABLE = 3'd5,
    EV_BAD_SIZE  = 3'd6
  } evt_t;

  typedef enum logic [10:0] {
    PH_HDR_TYPE   = 11'b000_0000_0001,
    PH_HDR_SIZE   = 11'b000_0000_0010,
    PH_HDR_HEIGHT = 11'b000_0000_0100,
    PH_HDR_WIDTH  = 11'b000_0000_1000,
    PH_BLK_TYPE   = 11'b000_0001_0000,
    PH_BLK_SIZE   = 11'b000_0010_0000,
    PH_STR_LEN    = 11'b000_0100_0000,
    PH_STR_DATA   = 11'b000_1000_0000,
    PH_FLT_DATA   = 11'b001_0000_0000,
    PH_BLANK_CNT  = 11'b010_0000_0000,
    PH_SKIP       = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic clear;
    logic hold_low;
    logic set_height;
    logic set_width;
    logic set_kind;
    logic set_block;
    logic dec_block;
    logic set_cell_len;
    logic str_byte;
    logic flt_byte;
    logic flt_wrap;
    logic advance;
    logic load_blank;
    logic emit;
    evt_t ev;
  } cmd_t;

  typedef struct packed {
    logic word_is_table;
    logic word_is_four;
    logic word_zero;
    logic kind_string;
    logic kind_float;
    logic kind_blank;
    logic byte_zero;
    logic block_le1;
    logic cell_left_one;
    logic cbc_ge7;
    logic blank_busy;
    logic out_full;
  } sts_t;

endpackage

FILE: rtl/xltable_stream_parser_core.sv
// ----------------------------------------------------------------------------
// xltable_stream_parser_core
// Byte-serial parser for binary table messages: header check, typed block
// walk, cell position tracking and one tagged result per payload byte.
//
//   Channel  Direction  Beat
//   in_      slave      one message byte, tlast on the final byte
//   out_     master     one tagged result (event in tuser, tlast = cell end)
//
// One byte is taken per cycle while the result register has room and no blank
// block is running. A blank block advances the cell position one cell per cycle
// after its count word; input is held off while the blank counter runs.
// A header error drops every further byte until the beat with tlast.
// Synchronous active-low reset; tlast also returns the parser to its start.
// A stalled result register holds off input, even a byte that yields no result.
// ----------------------------------------------------------------------------
module xltable_stream_parser_core #(
  parameter int unsigned COORD_BITS = xsp_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // data_byte
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // row[15:0], column[31:16], payload[39:32], byte_index[47:40],
  // table_height[63:48], table_width[79:64]
  output logic [xsp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [2:0]                      out_tuser,  // event_res
  output logic                            out_tlast
);
  import xsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  xsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  xsp_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/xsp_ctrl.sv
// ----------------------------------------------------------------------------
// xsp_ctrl
// Parse phase state machine; issues datapath commands per accepted byte.
// ----------------------------------------------------------------------------
module xsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  input  logic          out_tready,
  input  xsp_pkg::sts_t sts,
  output logic          in_tready,
  output xsp_pkg::cmd_t cmd
);
  import xsp_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   parity_r, parity_nxt;
  logic   halted_r, halted_nxt;
  logic   fire;

  assign in_tready = !sts.blank_busy && (!sts.out_full || out_tready);
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    cmd        = '0;
    cmd.ev     = EV_DIMS;
    phase_nxt  = phase_r;
    parity_nxt = parity_r;
    halted_nxt = halted_r;
    if (fire && !halted_r) begin
      case (phase_r)
        PH_STR_LEN: begin
          cmd.dec_block = 1'b1;
          if (sts.byte_zero) begin
            cmd.emit    = 1'b1;
            cmd.ev      = EV_STR_EMPTY;
            cmd.advance = 1'b1;
            phase_nxt   = sts.block_le1 ? PH_BLK_TYPE : PH_STR_LEN;
          end else begin
            cmd.set_cell_len = 1'b1;
            phase_nxt        = PH_STR_DATA;
          end
        end
        PH_STR_DATA: begin
          cmd.dec_block = 1'b1;
          cmd.emit      = 1'b1;
          cmd.ev        = EV_STR_BYTE;
          cmd.str_byte  = 1'b1;
          if (sts.cell_left_one) begin
            cmd.advance = 1'b1;
            phase_nxt   = sts.block_le1 ? PH_BLK_TYPE : PH_STR_LEN;
          end
        end
        PH_FLT_DATA: begin
          cmd.dec_block = 1'b1;
          cmd.emit      = 1'b1;
          cmd.ev        = EV_FLT_BYTE;
          cmd.flt_byte  = 1'b1;
          if (sts.cbc_ge7) begin
            cmd.flt_wrap = 1'b1;
            cmd.advance  = 1'b1;
            phase_nxt    = sts.block_le1 ? PH_BLK_TYPE : PH_FLT_DATA;
          end
        end
        PH_SKIP: begin
          cmd.dec_block = 1'b1;
          if (sts.block_le1) begin
            phase_nxt = PH_BLK_TYPE;
          end
        end
        default: begin
          if (!parity_r) begin
            cmd.hold_low = 1'b1;
            parity_nxt   = 1'b1;
          end else begin
            parity_nxt = 1'b0;
            case (phase_r)
              PH_HDR_TYPE: begin
                if (sts.word_is_table) begin
                  phase_nxt = PH_HDR_SIZE;
                end else begin
                  halted_nxt = 1'b1;
                  cmd.emit   = 1'b1;
                  cmd.ev     = EV_NOT_TABLE;
                end
              end
              PH_HDR_SIZE: begin
                if (sts.word_is_four) begin
                  phase_nxt = PH_HDR_HEIGHT;
                end else begin
                  halted_nxt = 1'b1;
                  cmd.emit   = 1'b1;
                  cmd.ev     = EV_BAD_SIZE;
                end
              end
              PH_HDR_HEIGHT: begin
                cmd.set_height = 1'b1;
                phase_nxt      = PH_HDR_WIDTH;
              end
              PH_HDR_WIDTH: begin
                cmd.set_width = 1'b1;
                cmd.emit      = 1'b1;
                cmd.ev        = EV_DIMS;
                phase_nxt     = PH_BLK_TYPE;
              end
              PH_BLK_TYPE: begin
                cmd.set_kind = 1'b1;
                phase_nxt    = PH_BLK_SIZE;
              end
              PH_BLK_SIZE: begin
                cmd.set_block = 1'b1;
                if (sts.kind_string) begin
                  phase_nxt = sts.word_zero ? PH_BLK_TYPE : PH_STR_LEN;
                end else if (sts.kind_float) begin
                  phase_nxt = sts.word_zero ? PH_BLK_TYPE : PH_FLT_DATA;
                end else if (sts.kind_blank) begin
                  phase_nxt = PH_BLANK_CNT;
                end else begin
                  cmd.emit  = 1'b1;
                  cmd.ev    = EV_UNKNOWN;
                  phase_nxt = sts.word_zero ? PH_BLK_TYPE : PH_SKIP;
                end
              end
              default: begin
                cmd.load_blank = 1'b1;
                phase_nxt      = PH_BLK_TYPE;
              end
            endcase
          end
        end
      endcase
    end
    if (fire && in_tlast) begin
      cmd.clear  = 1'b1;
      phase_nxt  = PH_HDR_TYPE;
      parity_nxt = 1'b0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR_TYPE;
      parity_r <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      parity_r <= parity_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

FILE: rtl/xsp_datapath.sv
// ----------------------------------------------------------------------------
// xsp_datapath
// Word assembly, block and cell counters, cell position and result register.
// ----------------------------------------------------------------------------
module xsp_datapath #(
  parameter int unsigned COORD_BITS = xsp_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [7:0]                      in_tdata,
  input  logic                            out_tready,
  input  xsp_pkg::cmd_t                   cmd,
  output xsp_pkg::sts_t                   sts,
  output logic                            out_tvalid,
  output logic [xsp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast
);
  import xsp_pkg::*;

  logic [7:0]            low_r;
  logic [15:0]           kind_r;
  logic [15:0]           block_left_r;
  logic [7:0]            cell_left_r;
  logic [7:0]            cbc_r;
  logic [COORD_BITS-1:0] row_r;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] width_r;
  logic [COORD_BITS-1:0] height_r;
  logic [15:0]           blank_left_r;

  logic [15:0]           word;
  logic [COORD_BITS-1:0] col_inc;
  logic                  wrap;
  logic                  blank_busy;
  logic                  adv;

  logic                  out_valid_r;
  logic [2:0]            ev_r;
  logic [15:0]           o_row_r, o_col_r, o_h_r, o_w_r;
  logic [7:0]            o_pay_r, o_idx_r;
  logic                  o_last_r;
  logic [7:0]            pay_nxt, idx_nxt;
  logic                  last_nxt;
  logic [15:0]           w_nxt;

  assign word       = {in_tdata, low_r};
  assign col_inc    = col_r + 1'b1;
  assign wrap       = (col_inc >= width_r);
  assign blank_busy = (blank_left_r != '0);
  assign adv        = cmd.advance || blank_busy;

  assign sts.word_is_table = (word == KIND_TABLE);
  assign sts.word_is_four  = (word == HDR_SIZE);
  assign sts.word_zero     = (word == '0);
  assign sts.kind_string   = (kind_r == KIND_STRING);
  assign sts.kind_float    = (kind_r == KIND_FLOAT);
  assign sts.kind_blank    = (kind_r == KIND_BLANK);
  assign sts.byte_zero     = (in_tdata == '0);
  assign sts.block_le1     = (block_left_r <= 16'd1);
  assign sts.cell_left_one = (cell_left_r == 8'd1);
  assign sts.cbc_ge7       = (cbc_r >= FLT_LAST);
  assign sts.blank_busy    = blank_busy;
  assign sts.out_full      = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      low_r        <= '0;
      kind_r       <= '0;
      block_left_r <= '0;
      cell_left_r  <= '0;
      cbc_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      width_r      <= '0;
      height_r     <= '0;
      blank_left_r <= '0;
    end else begin
      if (cmd.hold_low)   low_r    <= in_tdata;
      if (cmd.set_height) height_r <= word[COORD_BITS-1:0];
      if (cmd.set_width)  width_r  <= word[COORD_BITS-1:0];
      if (cmd.set_kind)   kind_r   <= word;
      if (cmd.set_block) begin
        block_left_r <= word;
        cell_left_r  <= '0;
        cbc_r        <= '0;
      end else if (cmd.dec_block && block_left_r != '0) begin
        block_left_r <= block_left_r - 1'b1;
      end
      if (cmd.set_cell_len) begin
        cell_left_r <= in_tdata;
        cbc_r       <= '0;
      end
      if (cmd.str_byte) begin
        cell_left_r <= cell_left_r - 1'b1;
        cbc_r       <= cbc_r + 1'b1;
      end
      if (cmd.flt_byte) begin
        cbc_r <= cmd.flt_wrap ? '0 : cbc_r + 1'b1;
      end
      if (cmd.load_blank) begin
        blank_left_r <= word;
      end else if (blank_busy) begin
        blank_left_r <= blank_left_r - 1'b1;
      end
      if (adv) begin
        col_r <= wrap ? '0 : col_inc;
        row_r <= wrap ? row_r + 1'b1 : row_r;
      end
    end
  end

  always_comb begin
    case (cmd.ev)
      EV_STR_BYTE, EV_FLT_BYTE:   pay_nxt = in_tdata;
      EV_UNKNOWN:                 pay_nxt = kind_r[7:0];
      EV_NOT_TABLE, EV_BAD_SIZE:  pay_nxt = low_r;
      default:                    pay_nxt = '0;
    endcase
    case (cmd.ev)
      EV_STR_BYTE, EV_FLT_BYTE:   idx_nxt = cbc_r;
      default:                    idx_nxt = '0;
    endcase
    case (cmd.ev)
      EV_STR_BYTE:  last_nxt = (cell_left_r == 8'd1);
      EV_FLT_BYTE:  last_nxt = (cbc_r == FLT_LAST);
      EV_STR_EMPTY: last_nxt = 1'b1;
      default:      last_nxt = 1'b0;
    endcase
    w_nxt = (cmd.ev == EV_DIMS) ? 16'(word[COORD_BITS-1:0]) : 16'(width_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ev_r     <= cmd.ev;
      o_row_r  <= 16'(row_r);
      o_col_r  <= 16'(col_r);
      o_pay_r  <= pay_nxt;
      o_idx_r  <= idx_nxt;
      o_last_r <= last_nxt;
      o_h_r    <= 16'(height_r);
      o_w_r    <= w_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ev_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {o_w_r, o_h_r, o_idx_r, o_pay_r, o_col_r, o_row_r};

endmodule

FILE: rtl/xsp_checker.sv
// ----------------------------------------------------------------------------
// xsp_checker
// Port-level checks on the table stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [xsp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [2:0]                      out_tuser,
  input logic                            out_tlast
);
  import xsp_pkg::*;

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  `XSP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  `XSP_ASSERT(a_rise_from_input, clk, rst_n, out_tvalid && !$past(out_tvalid) |-> $past(in_fire), "result without accepted byte")
  `XSP_NEVER(a_stall_blocks_input, clk, rst_n, out_tvalid && !out_tready && in_tready, "byte taken while result stalled")
  `XSP_ASSERT(a_cell_end_kind, clk, rst_n, out_tvalid && out_tlast |-> out_tuser == EV_STR_BYTE || out_tuser == EV_STR_EMPTY || out_tuser == EV_FLT_BYTE, "cell end on non-cell event")

endmodule

bind xltable_stream_parser_core xsp_checker u_xsp_checker (.*);
